// ===== design/mbpt_pkg.sv =====
// Package for the MIDI byte parser with note transpose.
// Holds MIDI byte codes, message lengths, the controller state type and
// the command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package mbpt_pkg;

    localparam logic [7:0] C_SYSEX_START   = 8'hF0;
    localparam logic [7:0] C_SYSEX_END     = 8'hF7;
    localparam logic [7:0] C_ONE_BYTE_MIN  = 8'hF4;
    localparam logic [7:0] C_MTC_QUARTER   = 8'hF1;
    localparam logic [7:0] C_SONG_SELECT   = 8'hF3;
    localparam logic [3:0] C_NOTE_OFF_HI   = 4'h8;
    localparam logic [3:0] C_NOTE_ON_HI    = 4'h9;
    localparam logic [3:0] C_PROG_CHG_HI   = 4'hC;
    localparam logic [3:0] C_CHAN_PRESS_HI = 4'hD;
    localparam logic [7:0] C_TRANSPOSE_RST = 8'd64;
    localparam logic [9:0] C_NOTE_CENTER   = 10'd64;
    localparam logic [6:0] C_DATA_MAX      = 7'd127;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic K_SHORT = 1'b0;
    localparam logic K_SYSEX = 1'b1;

    localparam logic [1:0] IDX_NONE   = 2'd0;
    localparam logic [1:0] IDX_FIRST  = 2'd1;
    localparam logic [1:0] IDX_SECOND = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PROC = 5'b00010,
        S_RD   = 5'b00100,
        S_OUT  = 5'b01000,
        S_F7   = 5'b10000
    } t_state;

    typedef struct packed {
        logic latch_rx;
        logic commit;
        logic flush_start;
        logic rd_issue;
        logic load_sysex;
        logic load_f7;
    } t_cmd;

    typedef struct packed {
        logic start_flush;
        logic needs_emit;
        logic out_free;
        logic last_data;
    } t_stat;

    function automatic logic [1:0] f_msg_len(input logic [7:0] s);
        logic [1:0] len;
        if (s[7:4] == C_PROG_CHG_HI || s[7:4] == C_CHAN_PRESS_HI) begin
            len = LEN_TWO;
        end else if (s >= C_ONE_BYTE_MIN) begin
            len = LEN_ONE;
        end else if (s == C_MTC_QUARTER || s == C_SONG_SELECT) begin
            len = LEN_TWO;
        end else begin
            len = LEN_THREE;
        end
        return len;
    endfunction

endpackage

// ===== design/mbpt_ifs.sv =====
// Request channel interfaces for the MIDI byte parser.
// Input channel carries one received byte, output channel one message result.
`timescale 1ns / 1ps

interface mbpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbpt_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte0;
    logic [6:0] byte1;
    logic [6:0] byte2;
    logic [1:0] msg_len;
    logic       last;

    modport source (output valid, output kind, output byte0, output byte1,
                    output byte2, output msg_len, output last, input ready);
    modport sink   (input valid, input kind, input byte0, input byte1,
                    input byte2, input msg_len, input last, output ready);
endinterface

// ===== design/mbpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbpt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mbpt_ctrl.sv =====
// Controller state machine for the MIDI byte parser.
// Depends on mbpt_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module mbpt_ctrl
    import mbpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_rx = 1'b1;
                    n_state        = S_PROC;
                end
            end
            S_PROC: begin
                if (i_stat.start_flush) begin
                    o_cmd.flush_start = 1'b1;
                    n_state           = S_RD;
                end else if (!i_stat.needs_emit || i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_sysex = 1'b1;
                    n_state          = i_stat.last_data ? S_F7 : S_RD;
                end
            end
            S_F7: begin
                if (i_stat.out_free) begin
                    o_cmd.load_f7 = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/mbpt_dp.sv =====
// Datapath for the MIDI byte parser: message assembly, transpose clamp,
// sysex capture buffer and output register. Depends on mbpt_pkg, mbpt_ram.
`timescale 1ns / 1ps

module mbpt_dp
    import mbpt_pkg::*;
#(
    parameter  int SYSEX_DEPTH = 64,
    localparam int AW          = $clog2(SYSEX_DEPTH)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_ready,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic       o_kind,
    output logic [7:0] o_byte0,
    output logic [6:0] o_byte1,
    output logic [6:0] o_byte2,
    output logic [1:0] o_msg_len,
    output logic       o_last
);

    logic [7:0]    r_transpose, n_transpose;
    logic [7:0]    r_rx, n_rx;
    logic          r_in_sysex, n_in_sysex;
    logic [AW-1:0] r_sx_count, n_sx_count;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]    r_pend_status, n_pend_status;
    logic [6:0]    r_pend_d1, n_pend_d1;
    logic [1:0]    r_byte_idx, n_byte_idx;
    logic [1:0]    r_exp_len, n_exp_len;

    logic          r_out_valid, n_out_valid;
    logic          r_kind, n_kind;
    logic [7:0]    r_byte0, n_byte0;
    logic [6:0]    r_byte1, n_byte1;
    logic [6:0]    r_byte2, n_byte2;
    logic [1:0]    r_msg_len, n_msg_len;
    logic          r_last, n_last;

    logic          w_is_status, w_is_f0, w_is_f7;
    logic [1:0]    w_len;
    logic          w_room;
    logic          w_needs_emit;
    logic [7:0]    w_st;
    logic [6:0]    w_d1_raw, w_d1, w_d2;
    logic [1:0]    w_emit_len;
    logic signed [9:0] w_note_sum;
    logic          w_out_free;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_rd_data;

    mbpt_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_DEPTH)
    ) u_sysex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_rx),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_is_status = r_rx[7];
    assign w_is_f0     = (r_rx == C_SYSEX_START);
    assign w_is_f7     = (r_rx == C_SYSEX_END);
    assign w_len       = f_msg_len(r_rx);
    assign w_room      = (r_sx_count < AW'(SYSEX_DEPTH - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_needs_emit = 1'b0;
        w_st         = r_pend_status;
        w_d1_raw     = r_rx[6:0];
        w_d2         = '0;
        w_emit_len   = LEN_TWO;
        if (!r_in_sysex && !w_is_f0) begin
            if (w_is_status) begin
                w_needs_emit = (w_len == LEN_ONE);
                w_st         = r_rx;
                w_d1_raw     = '0;
                w_emit_len   = LEN_ONE;
            end else if (r_byte_idx == IDX_FIRST) begin
                w_needs_emit = (r_exp_len <= LEN_TWO);
            end else if (r_byte_idx == IDX_SECOND) begin
                w_needs_emit = 1'b1;
                w_d1_raw     = r_pend_d1;
                w_d2         = r_rx[6:0];
                w_emit_len   = LEN_THREE;
            end
        end
    end

    assign w_note_sum = 10'({3'b000, w_d1_raw}) + 10'({2'b00, r_transpose}) - C_NOTE_CENTER;

    always_comb begin
        w_d1 = w_d1_raw;
        if (w_st[7:4] == C_NOTE_OFF_HI || w_st[7:4] == C_NOTE_ON_HI) begin
            if (w_note_sum[9]) begin
                w_d1 = '0;
            end else if (|w_note_sum[8:7]) begin
                w_d1 = C_DATA_MAX;
            end else begin
                w_d1 = w_note_sum[6:0];
            end
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        if (i_cmd.commit) begin
            if (r_in_sysex) begin
                w_wr_en   = w_room;
                w_wr_addr = r_sx_count;
            end else begin
                w_wr_en = w_is_f0;
            end
        end
    end

    assign o_stat.start_flush = r_in_sysex && w_is_f7;
    assign o_stat.needs_emit  = w_needs_emit;
    assign o_stat.out_free    = w_out_free;
    assign o_stat.last_data   = ((r_rd_idx + AW'(1)) == r_sx_count);

    always_comb begin
        n_transpose   = i_cfg_wr_en ? i_cfg_wr_data : r_transpose;
        n_rx          = i_cmd.latch_rx ? i_rx_byte : r_rx;
        n_in_sysex    = r_in_sysex;
        n_sx_count    = r_sx_count;
        n_rd_idx      = r_rd_idx;
        n_pend_status = r_pend_status;
        n_pend_d1     = r_pend_d1;
        n_byte_idx    = r_byte_idx;
        n_exp_len     = r_exp_len;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_kind        = r_kind;
        n_byte0       = r_byte0;
        n_byte1       = r_byte1;
        n_byte2       = r_byte2;
        n_msg_len     = r_msg_len;
        n_last        = r_last;

        if (i_cmd.commit) begin
            if (r_in_sysex) begin
                if (w_room) begin
                    n_sx_count = r_sx_count + AW'(1);
                end
            end else if (w_is_f0) begin
                n_in_sysex = 1'b1;
                n_sx_count = AW'(1);
            end else if (w_is_status) begin
                n_pend_status = r_rx;
                n_exp_len     = w_len;
                n_byte_idx    = (w_len == LEN_ONE) ? IDX_NONE : IDX_FIRST;
            end else if (r_byte_idx == IDX_FIRST) begin
                n_pend_d1  = r_rx[6:0];
                n_byte_idx = (r_exp_len <= LEN_TWO) ? IDX_NONE : IDX_SECOND;
            end else begin
                n_byte_idx = IDX_NONE;
            end
            if (w_needs_emit) begin
                n_out_valid = 1'b1;
                n_kind      = K_SHORT;
                n_byte0     = w_st;
                n_byte1     = w_d1;
                n_byte2     = w_d2;
                n_msg_len   = w_emit_len;
                n_last      = 1'b1;
            end
        end

        if (i_cmd.flush_start) begin
            n_rd_idx = '0;
        end

        if (i_cmd.load_sysex) begin
            n_rd_idx    = r_rd_idx + AW'(1);
            n_out_valid = 1'b1;
            n_kind      = K_SYSEX;
            n_byte0     = w_rd_data;
            n_byte1     = '0;
            n_byte2     = '0;
            n_msg_len   = LEN_ONE;
            n_last      = 1'b0;
        end

        if (i_cmd.load_f7) begin
            n_in_sysex  = 1'b0;
            n_sx_count  = '0;
            n_out_valid = 1'b1;
            n_kind      = K_SYSEX;
            n_byte0     = C_SYSEX_END;
            n_byte1     = '0;
            n_byte2     = '0;
            n_msg_len   = LEN_ONE;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose   <= C_TRANSPOSE_RST;
            r_in_sysex    <= 1'b0;
            r_sx_count    <= '0;
            r_rd_idx      <= '0;
            r_pend_status <= '0;
            r_pend_d1     <= '0;
            r_byte_idx    <= IDX_NONE;
            r_exp_len     <= LEN_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            r_transpose   <= n_transpose;
            r_in_sysex    <= n_in_sysex;
            r_sx_count    <= n_sx_count;
            r_rd_idx      <= n_rd_idx;
            r_pend_status <= n_pend_status;
            r_pend_d1     <= n_pend_d1;
            r_byte_idx    <= n_byte_idx;
            r_exp_len     <= n_exp_len;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx      <= n_rx;
        r_kind    <= n_kind;
        r_byte0   <= n_byte0;
        r_byte1   <= n_byte1;
        r_byte2   <= n_byte2;
        r_msg_len <= n_msg_len;
        r_last    <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_byte0     = r_byte0;
    assign o_byte1     = r_byte1;
    assign o_byte2     = r_byte2;
    assign o_msg_len   = r_msg_len;
    assign o_last      = r_last;

endmodule

// ===== design/midi_byte_parser_transpose.sv =====
// Channel       | Dir | Payload                                   | Handshake
// i_rx          | in  | rx_byte[7:0]                              | valid/ready
// o_msg         | out | kind, byte0[7:0], byte1, byte2, len, last | valid/ready
// i_cfg_wr_*    | in  | transpose[7:0]                            | write enable
//
// A byte is accepted, then processed; a byte that completes a
// message also waits for the output register to be free.
// A closing F7 reads each captured byte from the registered capture RAM
// port and loads it once the output register is free, then loads the F7.
// Reset is synchronous, active low; the capture RAM needs no clearing pass.
// Depends on mbpt_pkg, mbpt_ifs, mbpt_ctrl, mbpt_dp, mbpt_ram.
`timescale 1ns / 1ps

module midi_byte_parser_transpose
    import mbpt_pkg::*;
#(
    parameter int SYSEX_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mbpt_in_if.sink    i_rx,
    mbpt_out_if.source o_msg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    mbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_rx.ready),
        .o_cmd      (w_cmd)
    );

    mbpt_dp #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx.rx_byte),
        .i_out_ready   (o_msg.ready),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_msg.valid),
        .o_kind        (o_msg.kind),
        .o_byte0       (o_msg.byte0),
        .o_byte1       (o_msg.byte1),
        .o_byte2       (o_msg.byte2),
        .o_msg_len     (o_msg.msg_len),
        .o_last        (o_msg.last)
    );

endmodule

// ===== design/mbpt_checker.sv =====
// Port-level checker for the MIDI byte parser, bound to the top level.
// Depends on mbpt_pkg and midi_byte_parser_transpose.
`timescale 1ns / 1ps

module mbpt_checker
    import mbpt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_kind,
    input logic [7:0] i_byte0,
    input logic [6:0] i_byte1,
    input logic [6:0] i_byte2,
    input logic [1:0] i_msg_len,
    input logic       i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous byte still in process");

    a_short_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_SHORT |-> i_last && i_msg_len != LEN_NONE)
        else $error("short message without last or length");

    a_sysex_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_SYSEX |->
            i_msg_len == LEN_ONE && i_byte1 == '0 && i_byte2 == '0
            && (i_last == (i_byte0 == C_SYSEX_END)))
        else $error("malformed sysex result");

endmodule

bind midi_byte_parser_transpose mbpt_checker u_mbpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_msg.valid),
    .i_out_ready (o_msg.ready),
    .i_kind      (o_msg.kind),
    .i_byte0     (o_msg.byte0),
    .i_byte1     (o_msg.byte1),
    .i_byte2     (o_msg.byte2),
    .i_msg_len   (o_msg.msg_len),
    .i_last      (o_msg.last)
);

// ===== tb/sv/midi_byte_parser_transpose_test.sv =====
// Testbench for midi_byte_parser_transpose: drives MIDI bytes, predicts messages,
// checks every result request. Depends on mbpt_pkg, mbpt_ifs and the block RTL.
`timescale 1ns / 1ps

module midi_byte_parser_transpose_test;
    import mbpt_pkg::*;

    localparam int SYSEX_DEPTH = 64;
    localparam int PHASE_BYTES = 28;
    localparam int IDLE_PAUSE  = 8;

    localparam logic [3:0] ST_POLY_PRESS_HI = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG_HI   = 4'hB;
    localparam logic [3:0] ST_PITCH_BEND_HI = 4'hE;
    localparam logic [7:0] ST_CLOCK         = 8'hF8;
    localparam logic [7:0] ST_ACTIVE_SENSE  = 8'hFE;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte0;
        logic [6:0] byte1;
        logic [6:0] byte2;
        logic [1:0] msg_len;
        logic       last;
    } midi_result_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;

    mbpt_in_if  rx_if ();
    mbpt_out_if msg_if ();

    midi_byte_parser_transpose #(
        .SYSEX_DEPTH(SYSEX_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_rx         (rx_if),
        .o_msg        (msg_if)
    );

    // parser shadow state
    logic [7:0] note_shift = C_TRANSPOSE_RST;
    logic       sx_open    = 1'b0;
    int         sx_fill    = 0;
    logic [7:0] sx_buf [SYSEX_DEPTH];
    logic [7:0] run_status = 8'd0;
    logic [7:0] held_data1 = 8'd0;
    logic [1:0] data_pos   = IDX_NONE;
    logic [1:0] want_len   = LEN_NONE;

    logic [7:0]   midi_stream [$];
    midi_result_t parsed_msg_q [$];

    int fault_cnt    = 0;
    int bytes_sent   = 0;
    int msgs_checked = 0;
    int notes_seen   = 0;
    int flush_cnt    = 0;
    int shift_writes = 0;
    int send_left    = 0;
    int send_calm    = 0;
    int hold_left    = 0;
    int hold_calm    = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [1:0] span_of(input logic [7:0] st);
        if (st[7:4] == C_PROG_CHG_HI || st[7:4] == C_CHAN_PRESS_HI) return LEN_TWO;
        if (st >= C_ONE_BYTE_MIN) return LEN_ONE;
        if (st == C_MTC_QUARTER || st == C_SONG_SELECT) return LEN_TWO;
        return LEN_THREE;
    endfunction

    function automatic void expect_short(input logic [7:0] st, input logic [6:0] d1,
                                         input logic [6:0] d2, input logic [1:0] len);
        int pitch;
        midi_result_t m;
        pitch = int'(d1);
        if (st[7:4] == C_NOTE_OFF_HI || st[7:4] == C_NOTE_ON_HI) begin
            pitch = int'(d1) + int'(note_shift) - int'(C_NOTE_CENTER);
            if (pitch < 0) pitch = 0;
            if (pitch > int'(C_DATA_MAX)) pitch = int'(C_DATA_MAX);
            notes_seen++;
        end
        m = '{kind: K_SHORT, byte0: st, byte1: pitch[6:0], byte2: d2, msg_len: len,
              last: 1'b1};
        parsed_msg_q.push_back(m);
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        midi_result_t m;
        if (sx_open) begin
            if (b == C_SYSEX_END) begin
                for (int k = 0; k < sx_fill; k++) begin
                    m = '{kind: K_SYSEX, byte0: sx_buf[k], byte1: 7'd0, byte2: 7'd0,
                          msg_len: LEN_ONE, last: 1'b0};
                    parsed_msg_q.push_back(m);
                end
                m = '{kind: K_SYSEX, byte0: C_SYSEX_END, byte1: 7'd0, byte2: 7'd0,
                      msg_len: LEN_ONE, last: 1'b1};
                parsed_msg_q.push_back(m);
                sx_open = 1'b0;
                sx_fill = 0;
                flush_cnt++;
            end else if (sx_fill < SYSEX_DEPTH - 1) begin
                sx_buf[sx_fill] = b;
                sx_fill++;
            end
        end else if (b == C_SYSEX_START) begin
            sx_open   = 1'b1;
            sx_buf[0] = b;
            sx_fill   = 1;
        end else if (b[7]) begin
            run_status = b;
            want_len   = span_of(b);
            data_pos   = IDX_FIRST;
            if (want_len == LEN_ONE) begin
                data_pos = IDX_NONE;
                expect_short(b, 7'd0, 7'd0, LEN_ONE);
            end
        end else if (data_pos == IDX_FIRST) begin
            held_data1 = b;
            if (want_len == LEN_TWO) begin
                data_pos = IDX_NONE;
                expect_short(run_status, b[6:0], 7'd0, LEN_TWO);
            end else begin
                data_pos = IDX_SECOND;
            end
        end else if (data_pos == IDX_SECOND) begin
            data_pos = IDX_NONE;
            expect_short(run_status, held_data1[6:0], b[6:0], LEN_THREE);
        end
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return {1'b0, C_DATA_MAX};
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] rand_dump_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : rand_data();
        if (b == C_SYSEX_END) b = ST_CLOCK;
        return b;
    endfunction

    function automatic void queue_random_sequence();
        logic [7:0] st;
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            st[7:4] = (pick < 5) ? (pick[0] ? C_NOTE_ON_HI : C_NOTE_OFF_HI)
                                 : 4'($urandom_range(8, 14));
            st[3:0] = 4'($urandom);
            midi_stream.push_back(st);
            for (int k = 1; k < int'(span_of(st)); k++) midi_stream.push_back(rand_data());
        end else if (pick < 11) begin
            st = C_SYSEX_START + 8'($urandom_range(1, 6));
            midi_stream.push_back(st);
            for (int k = 1; k < int'(span_of(st)); k++) midi_stream.push_back(rand_data());
        end else if (pick < 13) begin
            midi_stream.push_back(C_ONE_BYTE_MIN + 8'($urandom_range(0, 11)));
        end else if (pick < 16) begin
            n = $urandom_range(0, 10);
            midi_stream.push_back(C_SYSEX_START);
            repeat (n) midi_stream.push_back(rand_dump_byte());
            midi_stream.push_back(C_SYSEX_END);
        end else if (pick == 16) begin
            st = {4'($urandom_range(8, 14)), 4'($urandom)};
            midi_stream.push_back(st);
            n = $urandom_range(0, int'(span_of(st)) - 2);
            repeat (n) midi_stream.push_back(rand_data());
        end else if (pick == 17) begin
            repeat ($urandom_range(1, 3)) midi_stream.push_back(rand_data());
        end else begin
            midi_stream.push_back(8'($urandom));
        end
    endfunction

    function automatic void flag_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        fault_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    endfunction

    always @(posedge i_clk) begin : drive_rx
        logic fire;
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'd0;
        end else begin
            fire = rx_if.valid && rx_if.ready;
            if (fire) begin
                parse_rx_byte(rx_if.rx_byte);
                bytes_sent++;
            end
            if (rx_if.valid && !fire) begin
                // hold the request until taken
            end else if (send_left > 0) begin
                send_left--;
                rx_if.valid <= 1'b0;
            end else if (midi_stream.size() > 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= midi_stream.pop_front();
                if (send_calm > 0) send_calm--;
                else if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(5, 30);
                send_left = (send_calm > 0) ? 0 : $urandom_range(0, 17);
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_msg
        midi_result_t want;
        midi_result_t got;
        if (!i_rst_n) begin
            msg_if.ready <= 1'b0;
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                got = '{kind: msg_if.kind, byte0: msg_if.byte0, byte1: msg_if.byte1,
                        byte2: msg_if.byte2, msg_len: msg_if.msg_len, last: msg_if.last};
                if (parsed_msg_q.size() == 0) begin
                    fault_cnt++;
                    $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                end else begin
                    want = parsed_msg_q.pop_front();
                    if (got.kind !== want.kind) flag_field("kind", want.kind, got.kind);
                    if (got.byte0 !== want.byte0) flag_field("byte0", want.byte0, got.byte0);
                    if (got.byte1 !== want.byte1) flag_field("byte1", want.byte1, got.byte1);
                    if (got.byte2 !== want.byte2) flag_field("byte2", want.byte2, got.byte2);
                    if (got.msg_len !== want.msg_len)
                        flag_field("msg_len", want.msg_len, got.msg_len);
                    if (got.last !== want.last) flag_field("last", want.last, got.last);
                end
                msgs_checked++;
                if (hold_calm > 0) hold_calm--;
                else if ($urandom_range(0, 9) == 0) hold_calm = $urandom_range(5, 30);
                hold_left = (hold_calm > 0) ? 0 : $urandom_range(0, 17);
            end
            if (hold_left > 0) begin
                hold_left--;
                msg_if.ready <= 1'b0;
            end else begin
                msg_if.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (midi_stream.size() != 0 || rx_if.valid || parsed_msg_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_transpose(input logic [7:0] v);
        wait_drained();
        repeat (IDLE_PAUSE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        note_shift = v;
        shift_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] shift, input int dump_len);
        write_transpose(shift);
        @(negedge i_clk);
        if (dump_len > 0) begin
            midi_stream.push_back(C_SYSEX_START);
            repeat (dump_len) midi_stream.push_back(rand_dump_byte());
            midi_stream.push_back(C_SYSEX_END);
        end
        while (midi_stream.size() < dump_len + PHASE_BYTES) queue_random_sequence();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'd0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'd0;
        msg_if.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_transpose(C_TRANSPOSE_RST);
        @(negedge i_clk);
        midi_stream = '{
            8'h00, 8'h7F,
            {C_NOTE_ON_HI, 4'h0}, 8'h00, 8'h7F,
            {C_NOTE_OFF_HI, 4'hF}, 8'h7F, 8'h00,
            {ST_CTRL_CHG_HI, 4'h3}, 8'h40, 8'h41, 8'h22,
            {C_PROG_CHG_HI, 4'h5}, 8'h7F,
            {C_CHAN_PRESS_HI, 4'h0}, 8'h01,
            {ST_POLY_PRESS_HI, 4'h0}, 8'h10, ST_ACTIVE_SENSE, 8'h20,
            {ST_PITCH_BEND_HI, 4'h9}, 8'h00, 8'h7F,
            C_MTC_QUARTER, 8'h12,
            C_SONG_SELECT, 8'h05,
            C_SYSEX_END,
            C_SYSEX_START, ST_CLOCK, C_SYSEX_END
        };

        run_phase(8'd0, 0);
        run_phase(8'd255, 0);
        run_phase(8'd128, 70);
        run_phase(8'($urandom_range(0, 128)), 0);
        run_phase(8'd127, 0);

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d bytes over %0d transpose settings; checked %0d results",
                 bytes_sent, shift_writes, msgs_checked);
        $display("including %0d note messages and %0d sysex flushes", notes_seen, flush_cnt);
        if (fault_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("%0t: timeout with %0d results outstanding", $time, parsed_msg_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
